/* rtl/rde_pkg.sv */
package rde_pkg;

   localparam int RADIX_WIDTH = 4;
   localparam int DIGIT_WIDTH = 5;

   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 4'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 4'd9;
   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 4'd8;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_POP  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

endpackage

/* rtl/radix_digit_emitter.sv */
// Channel   Direction  Ports                                  Meaning
// req       in         req_valid, req_stall, req_value        signed value to convert
// rsp       out        rsp_valid, rsp_stall, rsp_digit,       one digit, most significant
//                      rsp_last_digit                         first; last flags the final one
// csr       in         csr_write_enable, csr_write_data       radix, 2 to 9, reset 8
//
// Each digit comes from the bit-serial divider; all digits of an item are found
// before the first one is emitted.
// A zero value or a radix outside 2 to 9 is accepted but gives no item.
// Reset is synchronous; the digit stack is not cleared.
// A stall on rsp holds the current digit; req stays stalled until the run ends.
module radix_digit_emitter #(
   parameter int VALUE_WIDTH = 32,
   parameter int STACK_DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [VALUE_WIDTH-1:0]           req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [rde_pkg::DIGIT_WIDTH-1:0]  rsp_digit,
   output logic                                    rsp_last_digit,
   input  logic                                    csr_write_enable,
   input  logic [rde_pkg::RADIX_WIDTH-1:0]         csr_write_data
);
   import rde_pkg::*;

   localparam int ADDR_WIDTH = $clog2(STACK_DEPTH);
   localparam int CNT_WIDTH  = $clog2(STACK_DEPTH + 1);

   state_type              state_ff, state_in;
   logic [RADIX_WIDTH-1:0] radix_ff;
   logic                   neg_ff, neg_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [DIGIT_WIDTH-1:0] rd_data_ff;
   logic [DIGIT_WIDTH-1:0] stack_mem_ff [STACK_DEPTH];

   logic                   req_accept;
   logic                   rsp_accept;
   logic                   radix_ok;
   logic                   value_neg;
   logic [VALUE_WIDTH-1:0] magnitude;
   logic                   div_start;
   logic [VALUE_WIDTH-1:0] div_dividend;
   logic                   div_done;
   logic [VALUE_WIDTH-1:0] div_quotient;
   logic [RADIX_WIDTH-1:0] div_remainder;
   logic [DIGIT_WIDTH-1:0] rem_ext;
   logic [DIGIT_WIDTH-1:0] push_digit;
   logic                   push;
   logic                   pop;
   logic [ADDR_WIDTH-1:0]  pop_addr;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (state_ff == ST_EMIT);
   assign rsp_accept = rsp_valid && !rsp_stall;

   assign radix_ok  = (radix_ff >= RADIX_MIN) && (radix_ff <= RADIX_MAX);
   assign value_neg = req_value[VALUE_WIDTH-1];
   // The most negative value has a magnitude that still fits as unsigned.
   assign magnitude = value_neg ? (~req_value + VALUE_WIDTH'(1)) : req_value;

   // Digits of a negative value are the negated remainders.
   assign rem_ext    = {1'b0, div_remainder};
   assign push_digit = neg_ff ? (DIGIT_WIDTH'(0) - rem_ext) : rem_ext;
   assign push       = (state_ff == ST_DIV) && div_done;
   assign pop        = (state_ff == ST_POP);
   assign pop_addr   = ADDR_WIDTH'(cnt_ff - CNT_WIDTH'(1));

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      div_start    = 1'b0;
      div_dividend = magnitude;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && radix_ok && (magnitude != '0)) begin
               neg_in    = value_neg;
               cnt_in    = '0;
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               cnt_in = cnt_ff + CNT_WIDTH'(1);
               // Stop when the quotient runs out or the stack is full.
               if ((div_quotient == '0) || (cnt_ff == CNT_WIDTH'(STACK_DEPTH - 1))) begin
                  state_in = ST_POP;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = div_quotient;
               end
            end
         end
         ST_POP: begin
            cnt_in   = cnt_ff - CNT_WIDTH'(1);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_accept) begin
               state_in = (cnt_ff == '0) ? ST_IDLE : ST_POP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         radix_ff <= RADIX_RESET;
         neg_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         neg_ff   <= neg_in;
         cnt_ff   <= cnt_in;
         if (csr_write_enable) begin
            radix_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         stack_mem_ff[ADDR_WIDTH'(cnt_ff)] <= push_digit;
      end
      if (pop) begin
         rd_data_ff <= stack_mem_ff[pop_addr];
      end
   end

   rde_divider #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (radix_ff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign rsp_digit      = rd_data_ff;
   assign rsp_last_digit = (cnt_ff == '0);

endmodule

/* rtl/rde_divider.sv */
module rde_divider #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [VALUE_WIDTH-1:0]             dividend,
   input  logic [rde_pkg::RADIX_WIDTH-1:0]    divisor,
   output logic                               done,
   output logic [VALUE_WIDTH-1:0]             quotient,
   output logic [rde_pkg::RADIX_WIDTH-1:0]    remainder
);
   import rde_pkg::*;

   localparam int CNT_WIDTH = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [RADIX_WIDTH-1:0] rem_ff, rem_in;
   logic [RADIX_WIDTH:0]   trial;
   logic                   fits;

   // One restoring-division step per cycle: the dividend shifts out of the
   // top of quo_ff while quotient bits shift in at the bottom.
   assign trial = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign fits  = (trial >= {1'b0, divisor});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_WIDTH-2:0], fits};
         rem_in = fits ? RADIX_WIDTH'(trial - {1'b0, divisor}) : RADIX_WIDTH'(trial);
         cnt_in = cnt_ff + CNT_WIDTH'(1);
         if (cnt_ff == CNT_WIDTH'(VALUE_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* tb/radix_checker.sv */
module radix_checker #(
   parameter int VALUE_WIDTH = 32,
   parameter int STACK_DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_stall,
   input  logic signed [VALUE_WIDTH-1:0]           req_value,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   input  logic signed [rde_pkg::DIGIT_WIDTH-1:0]  rsp_digit,
   input  logic                                    rsp_last_digit,
   input  logic                                    csr_write_enable,
   input  logic [rde_pkg::RADIX_WIDTH-1:0]         csr_write_data,
   output int                                      pending,
   output int                                      failures
);
   timeunit 1ns;
   timeprecision 1ps;
   import rde_pkg::*;

   typedef struct {
      logic signed [DIGIT_WIDTH-1:0] digit;
      logic                          last_digit;
   } digit_item_type;

   digit_item_type          expected_digits[$];
   logic [RADIX_WIDTH-1:0]  radix_setting = RADIX_RESET;

   // Repeated division by the radix; remainders are truncated toward zero,
   // so a negative value yields digits that are zero or negative.
   function automatic void predict_digits(input logic signed [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH:0]    magnitude;
      logic [VALUE_WIDTH:0]    remainder;
      logic [DIGIT_WIDTH-1:0]  raw;
      logic [DIGIT_WIDTH-1:0]  digits_lsb_first[$];
      logic                    negative;
      digit_item_type          entry;
      if (radix_setting < RADIX_MIN || radix_setting > RADIX_MAX) begin
         return;
      end
      negative  = value[VALUE_WIDTH-1];
      magnitude = negative ? (~{value[VALUE_WIDTH-1], value} + 1'b1) : {1'b0, value};
      while (magnitude != 0 && digits_lsb_first.size() < STACK_DEPTH) begin
         remainder = magnitude % radix_setting;
         raw       = remainder[DIGIT_WIDTH-1:0];
         digits_lsb_first.push_back(negative ? (~raw + 1'b1) : raw);
         magnitude = magnitude / radix_setting;
      end
      for (int i = digits_lsb_first.size() - 1; i >= 0; i--) begin
         entry.digit      = digits_lsb_first[i];
         entry.last_digit = (i == 0);
         expected_digits.push_back(entry);
      end
   endfunction

   always @(posedge clock) begin : monitor
      digit_item_type want;
      if (reset) begin
         radix_setting = RADIX_RESET;
         expected_digits.delete();
      end else begin
         if (csr_write_enable) begin
            radix_setting = csr_write_data;
         end
         if (req_valid && !req_stall) begin
            predict_digits(req_value);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_digits.size() == 0) begin
               $display("%0t: unexpected digit %0d last %0b, none expected",
                        $time, rsp_digit, rsp_last_digit);
               failures++;
            end else begin
               want = expected_digits.pop_front();
               if (rsp_digit !== want.digit) begin
                  $display("%0t: digit mismatch, expected %0d, actual %0d",
                           $time, want.digit, rsp_digit);
                  failures++;
               end
               if (rsp_last_digit !== want.last_digit) begin
                  $display("%0t: last_digit mismatch, expected %0b, actual %0b",
                           $time, want.last_digit, rsp_last_digit);
                  failures++;
               end
            end
         end
      end
      pending = expected_digits.size();
   end

endmodule

/* tb/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rde_pkg::*;

   localparam int VALUE_WIDTH   = 32;
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES   = 400;
   localparam int STALL_LIMIT   = 8000;

   logic                          clock            = 1'b0;
   logic                          reset            = 1'b1;
   logic                          req_valid        = 1'b0;
   logic                          req_stall;
   logic signed [VALUE_WIDTH-1:0] req_value        = '0;
   logic                          rsp_valid;
   logic                          rsp_stall        = 1'b0;
   logic signed [DIGIT_WIDTH-1:0] rsp_digit;
   logic                          rsp_last_digit;
   logic                          csr_write_enable = 1'b0;
   logic [RADIX_WIDTH-1:0]        csr_write_data   = '0;

   int   pending;
   int   failures;
   int   quiet_cycles = 0;
   int   hold_left = 0;
   logic quiet = 1'b0;
   logic pressure_go = 1'b0;
   logic pressure_done = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   radix_digit_emitter #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digit        (rsp_digit),
      .rsp_last_digit   (rsp_last_digit),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   radix_checker #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digit        (rsp_digit),
      .rsp_last_digit   (rsp_last_digit),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .pending          (pending),
      .failures         (failures)
   );

   // Receiver: random stalls, plus one long hold-off so the block backs up.
   always @(posedge clock) begin
      if (pressure_go && !pressure_done) begin
         hold_left     = HOLD_CYCLES;
         pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 7);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_value(input logic signed [VALUE_WIDTH-1:0] value);
      while (!quiet && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
   endtask

   // A zero value or a bad radix leaves no digit behind, so after the last expected
   // digit the task still waits a settle period before the block counts as idle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_radix(input logic [RADIX_WIDTH-1:0] radix);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= radix;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic signed [VALUE_WIDTH-1:0] random_value();
      logic signed [VALUE_WIDTH-1:0] value;
      value = $urandom;
      case ($urandom_range(0, 9)) inside
         [0:3]: ;
         [4:6]: begin
            value = $urandom_range(1, 200);
            if ($urandom_range(0, 1)) value = -value;
         end
         7: value = value >>> $urandom_range(1, VALUE_WIDTH - 1);
         8: begin
            case ($urandom_range(0, 3))
               0: value = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
               1: value = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
               2: value = -1;
               default: value = 1;
            endcase
         end
         default: value = 0;
      endcase
      return value;
   endfunction

   initial begin
      logic [RADIX_WIDTH-1:0] radix;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset radix first, then both ends of the range, then invalid radices.
      send_value(0);
      send_value(1);
      send_value(-1);
      send_value(7);
      send_value(8);
      send_value(-8);
      send_value(-9);
      send_value(32'sh7FFFFFFF);
      send_value(32'sh80000000);
      send_value(32'sh55555555);
      send_value(32'shAAAAAAAA);
      set_radix(RADIX_MIN);
      send_value(32'sh7FFFFFFF);
      send_value(32'sh80000000);
      send_value(-1);
      send_value(5);
      set_radix(RADIX_MAX);
      send_value(8);
      send_value(-80);
      send_value(32'sh7FFFFFFF);
      send_value(32'sh80000000);
      set_radix(4'd1);
      send_value(5);
      send_value(-5);
      set_radix(4'd0);
      send_value(3);
      set_radix(4'd10);
      send_value(12);
      set_radix(4'd15);
      send_value(-1);

      for (int phase = 0; phase < 13; phase++) begin
         case (phase)
            0: radix = RADIX_MIN;
            1: radix = RADIX_MAX;
            6: radix = ($urandom_range(0, 1)) ? 4'($urandom_range(0, 1))
                                                : 4'($urandom_range(10, 15));
            default: radix = 4'($urandom_range(2, 9));
         endcase
         set_radix(radix);
         quiet = (phase == 3);
         if (phase == 8) pressure_go = 1'b1;
         for (int n = 0; n < ((phase == 6) ? 4 : 10); n++) begin
            send_value(random_value());
         end
         quiet = 1'b0;
      end

      wait_idle();
      if (failures == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         if (pending != 0) begin
            $display("%0t: %0d expected digits never arrived", $time, pending);
         end
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
